/* hdl/mtcp_pkg.sv */
// ----------------------------------------------------------------------------
// mtcp_pkg
// Shared sizes, codes, command format and request classification for the
// Modbus TCP server engine.
// ----------------------------------------------------------------------------
package mtcp_pkg;

  localparam int NUM_COILS        = 256;
  localparam int NUM_DISCRETE     = 256;
  localparam int NUM_INPUT_REGS   = 128;
  localparam int NUM_HOLDING_REGS = 128;
  localparam int MAX_DATA_BYTES   = 128;

  localparam int HDR_LEN     = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam int COIL_AW = $clog2(NUM_COILS);
  localparam int DISC_AW = $clog2(NUM_DISCRETE);
  localparam int IREG_AW = $clog2(NUM_INPUT_REGS) > 0 ? $clog2(NUM_INPUT_REGS) : 1;
  localparam int HREG_AW = $clog2(NUM_HOLDING_REGS) > 0 ? $clog2(NUM_HOLDING_REGS) : 1;
  localparam int MAX_AB  = COIL_AW > DISC_AW ? COIL_AW : DISC_AW;
  localparam int MAX_AR  = IREG_AW > HREG_AW ? IREG_AW : HREG_AW;
  localparam int TAB_AW  = MAX_AB > MAX_AR ? MAX_AB : MAX_AR;
  localparam int KW      = TAB_AW + 1;

  localparam logic [1:0] ACT_NET = 2'd0;
  localparam logic [1:0] ACT_WR  = 2'd1;
  localparam logic [1:0] ACT_RD  = 2'd2;

  localparam logic [1:0] SEL_COIL = 2'd0;
  localparam logic [1:0] SEL_DISC = 2'd1;
  localparam logic [1:0] SEL_IREG = 2'd2;
  localparam logic [1:0] SEL_HREG = 2'd3;

  localparam logic [7:0] FC_RD_COILS  = 8'd1;
  localparam logic [7:0] FC_RD_DISC   = 8'd2;
  localparam logic [7:0] FC_RD_HREGS  = 8'd3;
  localparam logic [7:0] FC_RD_IREGS  = 8'd4;
  localparam logic [7:0] FC_WR_COIL   = 8'd5;
  localparam logic [7:0] FC_WR_HREG   = 8'd6;
  localparam logic [7:0] FC_WR_COILS  = 8'd15;
  localparam logic [7:0] FC_WR_HREGS  = 8'd16;
  localparam logic [7:0] FC_EXC_FLAG  = 8'h80;

  localparam logic [1:0] EXC_NONE  = 2'd0;
  localparam logic [1:0] EXC_FUNC  = 2'd1;
  localparam logic [1:0] EXC_ADDR  = 2'd2;
  localparam logic [1:0] EXC_VALUE = 2'd3;

  localparam logic KIND_BYTES = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef logic [HDR_LEN-1:0][7:0] hdr_t;

  typedef enum logic [1:0] {
    WOP_NONE,
    WOP_WR,
    WOP_COIL8
  } wop_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WOP,
    ST_AREAD,
    ST_AOUT,
    ST_EXEC,
    ST_HDR,
    ST_BRD,
    ST_BACC,
    ST_BEMIT,
    ST_RRD,
    ST_RHI,
    ST_RLO
  } state_e;

  typedef struct packed {
    wop_e              wop;
    logic              rd;
    logic              resp;
    logic [1:0]        sel;
    logic [TAB_AW-1:0] idx;
    logic [15:0]       val;
    logic [7:0]        mask;
    logic              oor;
    hdr_t              hdr;
    logic [1:0]        err;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qpush_t;

  function automatic logic [1:0] range_chk(logic [16:0] nbytes, logic [16:0] sum, int size);
    logic [1:0] e;
    if (nbytes > 17'(MAX_DATA_BYTES)) e = EXC_VALUE;
    else if (sum > 17'(size))         e = EXC_ADDR;
    else                              e = EXC_NONE;
    return e;
  endfunction

  function automatic logic [1:0] classify(hdr_t h);
    logic [15:0] start;
    logic [15:0] count;
    logic [16:0] sum;
    logic [16:0] bbytes;
    logic [16:0] rbytes;
    logic [1:0]  e;
    start  = {h[8], h[9]};
    count  = {h[10], h[11]};
    sum    = {1'b0, start} + {1'b0, count};
    bbytes = ({1'b0, count} + 17'd7) >> 3;
    rbytes = {count, 1'b0};
    unique case (h[7]) inside
      FC_RD_COILS, FC_WR_COILS: e = range_chk(bbytes, sum, NUM_COILS);
      FC_RD_DISC:               e = range_chk(bbytes, sum, NUM_DISCRETE);
      FC_RD_HREGS, FC_WR_HREGS: e = range_chk(rbytes, sum, NUM_HOLDING_REGS);
      FC_RD_IREGS:              e = range_chk(rbytes, sum, NUM_INPUT_REGS);
      FC_WR_COIL:  e = ({1'b0, start} < 17'(NUM_COILS)) ? EXC_NONE : EXC_ADDR;
      FC_WR_HREG:  e = ({1'b0, start} < 17'(NUM_HOLDING_REGS)) ? EXC_NONE : EXC_ADDR;
      default:     e = EXC_FUNC;
    endcase
    return e;
  endfunction

endpackage

/* hdl/mtcp_req_if.sv */
// ----------------------------------------------------------------------------
// mtcp_req_if
// Request channel: network bytes and application table accesses.
// ----------------------------------------------------------------------------
interface mtcp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  rx_byte;
  logic [1:0]  table_sel;
  logic [7:0]  table_index;
  logic [15:0] table_value;

  modport source(output valid, action, rx_byte, table_sel, table_index, table_value,
                 input ready);
  modport sink(input valid, action, rx_byte, table_sel, table_index, table_value,
               output ready);
endinterface

/* hdl/mtcp_rsp_if.sv */
// ----------------------------------------------------------------------------
// mtcp_rsp_if
// Result channel: response byte groups and application read replies.
// ----------------------------------------------------------------------------
interface mtcp_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte0;
  logic [7:0]  tx_byte1;
  logic [7:0]  tx_byte2;
  logic [7:0]  tx_byte3;
  logic [2:0]  tx_count;
  logic        frame_last;
  logic [15:0] read_value;

  modport source(output valid, kind, tx_byte0, tx_byte1, tx_byte2, tx_byte3, tx_count,
                 frame_last, read_value, input ready);
  modport sink(input valid, kind, tx_byte0, tx_byte1, tx_byte2, tx_byte3, tx_count,
               frame_last, read_value, output ready);
endinterface

/* hdl/mtcp_front.sv */
// ----------------------------------------------------------------------------
// mtcp_front
// Frame tracker: collects the header, classifies the request and turns each
// accepted item into at most one table command.
// ----------------------------------------------------------------------------
module mtcp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  mtcp_req_if.sink         req,
  input  logic             q_full_i,
  output mtcp_pkg::qpush_t q_push_o
);
  import mtcp_pkg::*;

  logic [8:0]  pos_q, pos_d;
  hdr_t        hdr_q, hdr_d;
  logic        armed_q, armed_d;
  logic [7:0]  held_q, held_d;
  logic        accept;
  logic [1:0]  err_n;
  logic [7:0]  fc_n;
  logic [15:0] start_n, count_n;
  logic [7:0]  d;
  logic [16:0] k;
  logic [11:0] kk;
  logic [16:0] base;
  logic        inr;
  cmd_t        cmd;

  assign req.ready = !q_full_i;
  assign accept    = req.valid && req.ready;

  always_comb begin
    hdr_d   = (pos_q == 9'd0) ? '0 : hdr_q;
    if (pos_q < 9'(HDR_LEN)) hdr_d[pos_q[3:0]] = req.rx_byte;
    err_n   = classify(hdr_d);
    fc_n    = hdr_d[7];
    start_n = {hdr_d[8], hdr_d[9]};
    count_n = {hdr_d[10], hdr_d[11]};
    armed_d = (pos_q == 9'd0) ? 1'b0 : armed_q;
    held_d  = held_q;
    pos_d   = pos_q;
    d       = 8'(pos_q - 9'd13);
    k       = {1'b0, start_n} + 17'(d >> 1);
    base    = {1'b0, start_n} + 17'({d, 3'b000});
    cmd     = '0;
    inr     = 1'b0;
    kk      = '0;
    case (req.table_sel)
      SEL_COIL: inr = 17'(req.table_index) < 17'(NUM_COILS);
      SEL_DISC: inr = 17'(req.table_index) < 17'(NUM_DISCRETE);
      SEL_IREG: inr = 17'(req.table_index) < 17'(NUM_INPUT_REGS);
      default:  inr = 17'(req.table_index) < 17'(NUM_HOLDING_REGS);
    endcase
    case (req.action)
      ACT_WR: begin
        cmd.wop = inr ? WOP_WR : WOP_NONE;
        cmd.sel = req.table_sel;
        cmd.idx = TAB_AW'(req.table_index);
        cmd.val = req.table_value;
      end
      ACT_RD: begin
        cmd.rd  = 1'b1;
        cmd.sel = req.table_sel;
        cmd.idx = TAB_AW'(req.table_index);
        cmd.oor = !inr;
      end
      ACT_NET: begin
        if (pos_q == 9'd11) begin
          armed_d = (fc_n == FC_WR_COILS || fc_n == FC_WR_HREGS) && err_n == EXC_NONE;
        end
        if (pos_q >= 9'd13 && armed_d) begin
          if (fc_n == FC_WR_COILS) begin
            for (int j = 0; j < 8; j++) begin
              kk = {1'b0, d, 3'b000} + 12'(j);
              cmd.mask[j] = (16'(kk) < count_n) &&
                            ({1'b0, start_n} + 17'(kk) < 17'(NUM_COILS));
            end
            cmd.wop = (cmd.mask != 8'd0) ? WOP_COIL8 : WOP_NONE;
            cmd.sel = SEL_COIL;
            cmd.idx = base[TAB_AW-1:0];
            cmd.val = {8'd0, req.rx_byte};
          end else if (17'(d) < {count_n, 1'b0}) begin
            if (!d[0]) begin
              held_d = req.rx_byte;
            end else if (k < 17'(NUM_HOLDING_REGS)) begin
              cmd.wop = WOP_WR;
              cmd.sel = SEL_HREG;
              cmd.idx = k[TAB_AW-1:0];
              cmd.val = {held_q, req.rx_byte};
            end
          end
        end
        if (pos_q >= 9'd5 && pos_q == 9'd5 + 9'(hdr_d[5])) begin
          cmd.resp = 1'b1;
          cmd.hdr  = hdr_d;
          cmd.err  = err_n;
          pos_d    = '0;
          armed_d  = 1'b0;
        end else begin
          pos_d = pos_q + 9'd1;
        end
      end
      default: ;
    endcase
    q_push_o.cmd   = cmd;
    q_push_o.valid = accept && (cmd.wop != WOP_NONE || cmd.rd || cmd.resp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      armed_q <= 1'b0;
      held_q  <= '0;
      hdr_q   <= '0;
    end else if (accept && req.action == ACT_NET) begin
      pos_q   <= pos_d;
      armed_q <= armed_d;
      held_q  <= held_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

/* hdl/mtcp_queue.sv */
// ----------------------------------------------------------------------------
// mtcp_queue
// Command queue between frame tracker and table engine.
// ----------------------------------------------------------------------------
module mtcp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtcp_pkg::qpush_t push_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             nempty_o,
  output mtcp_pkg::cmd_t   head_o
);
  import mtcp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o   = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign nempty_o = cnt_q != '0;
  assign head_o   = mem_q[rp_q];
  assign do_push  = push_i.valid && !full_o;
  assign do_pop   = pop_i && nempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= push_i.cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + PW'(1);
      if (do_pop)  rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

/* hdl/mtcp_back.sv */
// ----------------------------------------------------------------------------
// mtcp_back
// Table engine: holds the four tables, carries out commands and builds the
// response frames four bytes at a time.
// ----------------------------------------------------------------------------
module mtcp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_nempty_i,
  input  mtcp_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  mtcp_rsp_if.source     rsp
);
  import mtcp_pkg::*;

  logic                   coil_mem [NUM_COILS];
  logic                   disc_mem [NUM_DISCRETE];
  logic [15:0]            ireg_mem [NUM_INPUT_REGS];
  logic [15:0]            hreg_mem [NUM_HOLDING_REGS];
  logic [TAB_AW-1:0]      clr_q;
  logic                   clr_en;

  state_e      state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [2:0]  j_q, j_d;
  logic [3:0]  i_q, i_d;
  logic [KW-1:0] k_q, k_d;
  logic [7:0]  acc_q, acc_d;
  logic [7:0]  bi_q, bi_d;
  logic [15:0] rdata_q;

  logic              wr_en, rd_en;
  logic [1:0]        wr_sel, rd_sel;
  logic [TAB_AW-1:0] wr_addr, rd_addr;
  logic [15:0]       wr_val;
  logic              push, push_last, app_load, form, out_free;
  logic [7:0]        push_byte;

  logic [7:0]  pk_q [3];
  logic [1:0]  pk_cnt_q;

  logic [7:0]  fc;
  logic [15:0] start, count;
  logic        is_err, is_bits, is_read, is_echo;
  logic [7:0]  n, hb;
  logic [3:0]  hlen_m1;
  logic [15:0] bb;
  state_e      after_wop;
  logic [TAB_AW-1:0] a_k;

  assign out_free = !rsp.valid || rsp.ready;
  assign clr_en   = state_q == ST_CLEAR;

  always_comb begin
    fc      = cur_q.hdr[7];
    start   = {cur_q.hdr[8], cur_q.hdr[9]};
    count   = {cur_q.hdr[10], cur_q.hdr[11]};
    is_err  = cur_q.err != EXC_NONE;
    is_bits = fc == FC_RD_COILS || fc == FC_RD_DISC;
    is_read = !is_err && (is_bits || fc == FC_RD_HREGS || fc == FC_RD_IREGS);
    is_echo = !is_err && !is_read;
    bb      = (count + 16'd7) >> 3;
    n       = is_bits ? bb[7:0] : {count[6:0], 1'b0};
    hlen_m1 = is_echo ? 4'(HDR_LEN - 1) : 4'd8;
    a_k     = start[TAB_AW-1:0] + k_q[TAB_AW-1:0];
    case (i_q)
      4'd5:    hb = is_err ? 8'd3 : (is_echo ? 8'd6 : n + 8'd3);
      4'd7:    hb = is_err ? (fc | FC_EXC_FLAG) : fc;
      4'd8:    hb = is_err ? {6'd0, cur_q.err} : (is_echo ? cur_q.hdr[8] : n);
      default: hb = cur_q.hdr[i_q];
    endcase
    if (cur_q.rd)        after_wop = ST_AREAD;
    else if (cur_q.resp) after_wop = ST_EXEC;
    else                 after_wop = ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clr_en) clr_q <= clr_q + TAB_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    j_q   <= j_d;
    i_q   <= i_d;
    k_q   <= k_d;
    acc_q <= acc_d;
    bi_q  <= bi_d;
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    j_d       = j_q;
    i_d       = i_q;
    k_d       = k_q;
    acc_d     = acc_q;
    bi_d      = bi_q;
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;
    wr_sel    = cur_q.sel;
    wr_addr   = cur_q.idx;
    wr_val    = cur_q.val;
    rd_en     = 1'b0;
    rd_sel    = cur_q.sel;
    rd_addr   = cur_q.idx;
    push      = 1'b0;
    push_byte = '0;
    push_last = 1'b0;
    app_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_nempty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          j_d     = '0;
          state_d = ST_WOP;
        end
      end
      ST_WOP: begin
        unique case (cur_q.wop)
          WOP_WR: begin
            wr_en   = 1'b1;
            state_d = after_wop;
          end
          WOP_COIL8: begin
            wr_en   = cur_q.mask[j_q];
            wr_addr = cur_q.idx + TAB_AW'(j_q);
            wr_val  = {15'd0, cur_q.val[{1'b0, j_q}]};
            j_d     = j_q + 3'd1;
            if (j_q == 3'd7) state_d = after_wop;
          end
          default: state_d = after_wop;
        endcase
      end
      ST_AREAD: begin
        rd_en   = 1'b1;
        state_d = ST_AOUT;
      end
      ST_AOUT: begin
        if (out_free) begin
          app_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_EXEC: begin
        wr_addr = start[TAB_AW-1:0];
        if (!is_err && fc == FC_WR_COIL) begin
          wr_en  = 1'b1;
          wr_sel = SEL_COIL;
          wr_val = {15'd0, count != 16'd0};
        end else if (!is_err && fc == FC_WR_HREG) begin
          wr_en  = 1'b1;
          wr_sel = SEL_HREG;
          wr_val = count;
        end
        i_d     = '0;
        state_d = ST_HDR;
      end
      ST_HDR: begin
        push_byte = hb;
        push_last = (i_q == hlen_m1) && !(is_read && n != 8'd0);
        if (out_free || (pk_cnt_q != 2'd3 && !push_last)) begin
          push = 1'b1;
          i_d  = i_q + 4'd1;
          if (push_last) begin
            state_d = ST_IDLE;
          end else if (i_q == hlen_m1) begin
            k_d     = '0;
            bi_d    = '0;
            acc_d   = '0;
            state_d = is_bits ? ST_BRD : ST_RRD;
          end
        end
      end
      ST_BRD: begin
        rd_en   = 1'b1;
        rd_sel  = (fc == FC_RD_COILS) ? SEL_COIL : SEL_DISC;
        rd_addr = a_k;
        state_d = ST_BACC;
      end
      ST_BACC: begin
        acc_d[k_q[2:0]] = rdata_q[0] && (16'(k_q) < count);
        k_d = k_q + KW'(1);
        if (k_q[2:0] == 3'd7) begin
          state_d = ST_BEMIT;
        end else begin
          rd_en   = 1'b1;
          rd_sel  = (fc == FC_RD_COILS) ? SEL_COIL : SEL_DISC;
          rd_addr = a_k + TAB_AW'(1);
        end
      end
      ST_BEMIT: begin
        push_byte = acc_q;
        push_last = bi_q == n - 8'd1;
        if (out_free || (pk_cnt_q != 2'd3 && !push_last)) begin
          push    = 1'b1;
          bi_d    = bi_q + 8'd1;
          acc_d   = '0;
          state_d = push_last ? ST_IDLE : ST_BRD;
        end
      end
      ST_RRD: begin
        rd_en   = 1'b1;
        rd_sel  = (fc == FC_RD_HREGS) ? SEL_HREG : SEL_IREG;
        rd_addr = a_k;
        state_d = ST_RHI;
      end
      ST_RHI: begin
        push_byte = rdata_q[15:8];
        if (out_free || pk_cnt_q != 2'd3) begin
          push    = 1'b1;
          state_d = ST_RLO;
        end
      end
      ST_RLO: begin
        push_byte = rdata_q[7:0];
        push_last = 16'(k_q) + 16'd1 == count;
        if (out_free || (pk_cnt_q != 2'd3 && !push_last)) begin
          push    = 1'b1;
          k_d     = k_q + KW'(1);
          state_d = push_last ? ST_IDLE : ST_RRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // table storage
  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      coil_mem[clr_q[COIL_AW-1:0]] <= 1'b0;
      disc_mem[clr_q[DISC_AW-1:0]] <= 1'b0;
      ireg_mem[clr_q[IREG_AW-1:0]] <= '0;
      hreg_mem[clr_q[HREG_AW-1:0]] <= '0;
    end else if (wr_en) begin
      case (wr_sel)
        SEL_COIL: coil_mem[wr_addr[COIL_AW-1:0]] <= wr_val[0];
        SEL_DISC: disc_mem[wr_addr[DISC_AW-1:0]] <= wr_val[0];
        SEL_IREG: ireg_mem[wr_addr[IREG_AW-1:0]] <= wr_val;
        default:  hreg_mem[wr_addr[HREG_AW-1:0]] <= wr_val;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      case (rd_sel)
        SEL_COIL: rdata_q <= {15'd0, coil_mem[rd_addr[COIL_AW-1:0]]};
        SEL_DISC: rdata_q <= {15'd0, disc_mem[rd_addr[DISC_AW-1:0]]};
        SEL_IREG: rdata_q <= ireg_mem[rd_addr[IREG_AW-1:0]];
        default:  rdata_q <= hreg_mem[rd_addr[HREG_AW-1:0]];
      endcase
    end
  end

  // byte packer and output register
  assign form = push && (push_last || pk_cnt_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (push && !form) pk_q[pk_cnt_q] <= push_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_cnt_q       <= '0;
      rsp.valid      <= 1'b0;
      rsp.kind       <= KIND_BYTES;
      rsp.tx_byte0   <= '0;
      rsp.tx_byte1   <= '0;
      rsp.tx_byte2   <= '0;
      rsp.tx_byte3   <= '0;
      rsp.tx_count   <= '0;
      rsp.frame_last <= 1'b0;
      rsp.read_value <= '0;
    end else begin
      if (form)      pk_cnt_q <= '0;
      else if (push) pk_cnt_q <= pk_cnt_q + 2'd1;
      if (app_load) begin
        rsp.valid      <= 1'b1;
        rsp.kind       <= KIND_READ;
        rsp.tx_byte0   <= '0;
        rsp.tx_byte1   <= '0;
        rsp.tx_byte2   <= '0;
        rsp.tx_byte3   <= '0;
        rsp.tx_count   <= '0;
        rsp.frame_last <= 1'b0;
        rsp.read_value <= cur_q.oor ? 16'd0 : rdata_q;
      end else if (form) begin
        rsp.valid      <= 1'b1;
        rsp.kind       <= KIND_BYTES;
        rsp.tx_byte0   <= (pk_cnt_q == 2'd0) ? push_byte : pk_q[0];
        rsp.tx_byte1   <= (pk_cnt_q > 2'd1) ? pk_q[1] :
                          ((pk_cnt_q == 2'd1) ? push_byte : 8'd0);
        rsp.tx_byte2   <= (pk_cnt_q > 2'd2) ? pk_q[2] :
                          ((pk_cnt_q == 2'd2) ? push_byte : 8'd0);
        rsp.tx_byte3   <= (pk_cnt_q == 2'd3) ? push_byte : 8'd0;
        rsp.tx_count   <= 3'(pk_cnt_q) + 3'd1;
        rsp.frame_last <= push_last;
        rsp.read_value <= '0;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/modbus_tcp_slave_engine_core.sv */
// ----------------------------------------------------------------------------
// modbus_tcp_slave_engine_core
// Modbus TCP server engine: frame tracker, command queue and table engine.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    action, rx_byte, table_sel, table_index,
//                                table_value
//   rsp      out  valid/ready    kind, tx_byte0..3, tx_count, frame_last,
//                                read_value
//
// Request bytes and table writes are taken one a cycle while the queue has room.
// The engine handles table writes, streamed coil bytes, read replies and response
// headers one command at a time; bit-data bytes and registers are fetched through
// the single table read port.
// Reset starts a pass that clears all tables; the queue takes up to four commands
// meanwhile, then holds the request channel.
// The output register lets the engine keep working while a group waits.
// ----------------------------------------------------------------------------
module modbus_tcp_slave_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtcp_req_if.sink   req,
  mtcp_rsp_if.source rsp
);
  import mtcp_pkg::*;

  qpush_t q_push;
  logic   q_full, q_pop, q_nempty;
  cmd_t   q_head;

  mtcp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .q_full_i (q_full),
    .q_push_o (q_push)
  );

  mtcp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .nempty_o (q_nempty),
    .head_o   (q_head)
  );

  mtcp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_nempty_i (q_nempty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .rsp        (rsp)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Modbus TCP server engine. A queue of request
// frames, table writes and table reads drives the request channel; a predictor
// tracks frames and tables and queues the expected response groups and read
// replies, which the monitor compares field by field as they arrive.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtcp_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 400;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [1:0]  sel;
    logic [7:0]  idx;
    logic [15:0] val;
  } req_item_t;

  typedef struct {
    logic        kind;
    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  cnt;
    logic        last;
    logic [15:0] rval;
  } rsp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mtcp_req_if req ();
  mtcp_rsp_if rsp ();

  modbus_tcp_slave_engine_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  always #6 clk_i = ~clk_i;

  req_item_t stim_q[$];
  rsp_item_t pending_rsp_q[$];
  int        n_total;
  int        n_taken;
  int        n_errors;
  int        cycles;
  bit        taken;

  // predictor state
  logic [7:0]  hdr[HDR_LEN];
  logic [8:0]  fpos;
  logic        coils[NUM_COILS];
  logic        discs[NUM_DISCRETE];
  logic [15:0] iregs[NUM_INPUT_REGS];
  logic [15:0] hregs[NUM_HOLDING_REGS];
  logic [7:0]  held_high;
  logic        wr_armed;

  function automatic int hword(int at);
    return {hdr[at], hdr[at+1]};
  endfunction

  function automatic int range_err(int start, int count, int nbytes, int size);
    if (nbytes > MAX_DATA_BYTES) return EXC_VALUE;
    if (start + count > size) return EXC_ADDR;
    return EXC_NONE;
  endfunction

  function automatic int judge_request();
    int s, c;
    s = hword(8);
    c = hword(10);
    case (hdr[7])
      FC_RD_COILS, FC_WR_COILS: return range_err(s, c, (c + 7) / 8, NUM_COILS);
      FC_RD_DISC:               return range_err(s, c, (c + 7) / 8, NUM_DISCRETE);
      FC_RD_HREGS, FC_WR_HREGS: return range_err(s, c, c * 2, NUM_HOLDING_REGS);
      FC_RD_IREGS:              return range_err(s, c, c * 2, NUM_INPUT_REGS);
      FC_WR_COIL:               return s < NUM_COILS ? EXC_NONE : EXC_ADDR;
      FC_WR_HREG:               return s < NUM_HOLDING_REGS ? EXC_NONE : EXC_ADDR;
      default:                  return EXC_FUNC;
    endcase
  endfunction

  function automatic void stream_data(int d, logic [7:0] b);
    int s, c, k;
    s = hword(8);
    c = hword(10);
    if (hdr[7] == FC_WR_COILS) begin
      for (int j = 0; j < 8; j++) begin
        k = d * 8 + j;
        if (k < c && s + k < NUM_COILS) coils[s+k] = b[j];
      end
    end else if (d < c * 2) begin
      if (d % 2 == 0) held_high = b;
      else if (s + d / 2 < NUM_HOLDING_REGS) hregs[s + d/2] = {held_high, b};
    end
  endfunction

  function automatic void queue_groups(ref logic [7:0] buf_q[$]);
    rsp_item_t r;
    int len, ng;
    logic [7:0] g[4];
    len = buf_q.size();
    ng = (len + 3) / 4;
    for (int i = 0; i < ng; i++) begin
      for (int c = 0; c < 4; c++) g[c] = (i * 4 + c < len) ? buf_q[i*4+c] : 8'h00;
      r.kind = KIND_BYTES;
      {r.b0, r.b1, r.b2, r.b3} = {g[0], g[1], g[2], g[3]};
      r.cnt = (len - i * 4) < 4 ? 3'(len - i * 4) : 3'd4;
      r.last = (i == ng - 1);
      r.rval = '0;
      pending_rsp_q.push_back(r);
    end
  endfunction

  function automatic void serve_frame();
    logic [7:0] buf_q[$];
    logic [7:0] fc, v;
    int s, c, n, err;
    fc = hdr[7];
    s = hword(8);
    c = hword(10);
    err = judge_request();
    for (int i = 0; i < 8; i++) buf_q.push_back(hdr[i]);
    if (err != EXC_NONE) begin
      buf_q[5] = 8'd3;
      buf_q[7] = fc | FC_EXC_FLAG;
      buf_q.push_back(8'(err));
    end else if (fc == FC_WR_COIL || fc == FC_WR_HREG || fc == FC_WR_COILS ||
                 fc == FC_WR_HREGS) begin
      if (fc == FC_WR_COIL) coils[s] = (c != 0);
      if (fc == FC_WR_HREG) hregs[s] = 16'(c);
      for (int i = 8; i < HDR_LEN; i++) buf_q.push_back(hdr[i]);
      buf_q[5] = 8'd6;
    end else begin
      if (fc == FC_RD_COILS || fc == FC_RD_DISC) begin
        n = (c + 7) / 8;
        buf_q.push_back(8'(n));
        for (int i = 0; i < n; i++) begin
          v = '0;
          for (int j = 0; j < 8; j++)
            if (i * 8 + j < c)
              v[j] = (fc == FC_RD_COILS) ? coils[s + i*8 + j] : discs[s + i*8 + j];
          buf_q.push_back(v);
        end
      end else begin
        n = c * 2;
        buf_q.push_back(8'(n));
        for (int i = 0; i < c; i++) begin
          v = (fc == FC_RD_HREGS) ? hregs[s+i][15:8] : iregs[s+i][15:8];
          buf_q.push_back(v);
          v = (fc == FC_RD_HREGS) ? hregs[s+i][7:0] : iregs[s+i][7:0];
          buf_q.push_back(v);
        end
      end
      buf_q[5] = 8'(n + 3);
    end
    queue_groups(buf_q);
  endfunction

  function automatic void model_request(req_item_t it);
    rsp_item_t r;
    int p, err;
    case (it.action)
      ACT_WR: begin
        case (it.sel)
          SEL_COIL: if (it.idx < NUM_COILS) coils[it.idx] = it.val[0];
          SEL_DISC: if (it.idx < NUM_DISCRETE) discs[it.idx] = it.val[0];
          SEL_IREG: if (it.idx < NUM_INPUT_REGS) iregs[it.idx] = it.val;
          default:  if (it.idx < NUM_HOLDING_REGS) hregs[it.idx] = it.val;
        endcase
      end
      ACT_RD: begin
        r = '{kind: KIND_READ, b0: 0, b1: 0, b2: 0, b3: 0, cnt: 0, last: 0, rval: 0};
        case (it.sel)
          SEL_COIL: if (it.idx < NUM_COILS) r.rval = coils[it.idx];
          SEL_DISC: if (it.idx < NUM_DISCRETE) r.rval = discs[it.idx];
          SEL_IREG: if (it.idx < NUM_INPUT_REGS) r.rval = iregs[it.idx];
          default:  if (it.idx < NUM_HOLDING_REGS) r.rval = hregs[it.idx];
        endcase
        pending_rsp_q.push_back(r);
      end
      ACT_NET: begin
        p = fpos;
        if (p == 0) begin
          foreach (hdr[i]) hdr[i] = '0;
          wr_armed = 1'b0;
        end
        if (p < HDR_LEN) hdr[p] = it.rx_byte;
        if (p == 11) begin
          err = judge_request();
          wr_armed = (hdr[7] == FC_WR_COILS || hdr[7] == FC_WR_HREGS) && err == EXC_NONE;
        end
        if (p >= 13 && wr_armed) stream_data(p - 13, it.rx_byte);
        if (p >= 5 && p + 1 == 6 + hdr[5]) begin
          fpos = '0;
          wr_armed = 1'b0;
          serve_frame();
        end else begin
          fpos = 9'(p + 1);
        end
      end
      default: ;
    endcase
  endfunction

  // stimulus builders
  task automatic add_item(logic [1:0] a, logic [7:0] b, logic [1:0] s, logic [7:0] i,
                          logic [15:0] v);
    req_item_t it;
    it = '{action: a, rx_byte: b, sel: s, idx: i, val: v};
    stim_q.push_back(it);
  endtask

  task automatic add_frame(logic [7:0] fc, logic [15:0] a, logic [15:0] c, int ndata,
                           int short_len);
    logic [7:0] body[$];
    body = '{8'($urandom), fc, a[15:8], a[7:0], c[15:8], c[7:0]};
    if (ndata >= 0) begin
      body.push_back(8'(ndata));
      for (int i = 0; i < ndata; i++) body.push_back(8'($urandom));
    end
    if (short_len >= 0)
      while (body.size() > short_len) void'(body.pop_back());
    for (int i = 0; i < 5; i++) add_item(ACT_NET, 8'($urandom), 2'($urandom), 8'($urandom),
                                         16'($urandom));
    add_item(ACT_NET, 8'(body.size()), 2'($urandom), 8'($urandom), 16'($urandom));
    foreach (body[i]) add_item(ACT_NET, body[i], 2'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic add_random_frame();
    int pick, c, s, nd;
    logic [7:0] fc;
    pick = $urandom_range(7);
    case (pick)
      0, 1: begin
        fc = pick == 0 ? FC_RD_COILS : FC_RD_DISC;
        c = $urandom_range(40);
        s = $urandom_range(256 - c);
        add_frame(fc, 16'(s), 16'(c), -1, -1);
      end
      2, 3: begin
        fc = pick == 2 ? FC_RD_HREGS : FC_RD_IREGS;
        c = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(10);
        s = $urandom_range(128 - c);
        add_frame(fc, 16'(s), 16'(c), -1, -1);
      end
      4: add_frame(FC_WR_COIL, 16'($urandom_range(255)), 16'($urandom), -1, -1);
      5: add_frame(FC_WR_HREG, 16'($urandom_range(127)), 16'($urandom), -1, -1);
      6: begin
        c = $urandom_range(1, 40);
        s = $urandom_range(256 - c);
        nd = (c + 7) / 8;
        if ($urandom_range(4) == 0) nd = $urandom_range(nd + 2);
        add_frame(FC_WR_COILS, 16'(s), 16'(c), nd, -1);
      end
      default: begin
        c = $urandom_range(1, 10);
        s = $urandom_range(128 - c);
        nd = 2 * c;
        if ($urandom_range(4) == 0) nd = $urandom_range(nd + 3);
        add_frame(FC_WR_HREGS, 16'(s), 16'(c), nd, -1);
      end
    endcase
  endtask

  task automatic add_noise();
    logic [7:0] fc;
    case ($urandom_range(4))
      0: begin
        do fc = 8'($urandom);
        while (fc inside {[1:6], 15, 16});
        add_frame(fc, 16'($urandom), 16'($urandom), -1, -1);
      end
      1: add_frame(8'($urandom_range(1, 6)), 16'($urandom), 16'($urandom), -1, -1);
      2: add_frame(8'($urandom_range(1, 6)), 16'($urandom), 16'($urandom), -1,
                   $urandom_range(5));
      3: add_frame(8'($urandom_range(15, 16)), 16'($urandom_range(300)),
                   16'($urandom_range(300)), $urandom_range(20), -1);
      default: add_item(2'd3, 8'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      model_request('{action: req.action, rx_byte: req.rx_byte, sel: req.table_sel,
                      idx: req.table_index, val: req.table_value});
      n_taken++;
      taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    int sidle, ridle, ph;
    req_item_t it;
    ph = n_total > 0 ? (n_taken * 3) / n_total : 0;
    sidle = ph == 0 ? 8 : (ph == 1 ? 68 : 0);
    ridle = ph == 0 ? 68 : (ph == 1 ? 8 : 0);
    if (rst_ni) begin
      if (!req.valid || taken) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= sidle) begin
          it = stim_q.pop_front();
          req.action      <= it.action;
          req.rx_byte     <= it.rx_byte;
          req.table_sel   <= it.sel;
          req.table_index <= it.idx;
          req.table_value <= it.val;
          req.valid       <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
      rsp.ready <= ($urandom_range(99) >= ridle);
    end
    taken = 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_item_t e;
    if (rsp.valid && rsp.ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("unexpected response: kind %0d count %0d", rsp.kind, rsp.tx_count);
        n_errors++;
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, rsp.kind); n_errors++;
        end
        if (rsp.tx_byte0 !== e.b0) begin
          $error("tx_byte0: expected %0h, got %0h", e.b0, rsp.tx_byte0); n_errors++;
        end
        if (rsp.tx_byte1 !== e.b1) begin
          $error("tx_byte1: expected %0h, got %0h", e.b1, rsp.tx_byte1); n_errors++;
        end
        if (rsp.tx_byte2 !== e.b2) begin
          $error("tx_byte2: expected %0h, got %0h", e.b2, rsp.tx_byte2); n_errors++;
        end
        if (rsp.tx_byte3 !== e.b3) begin
          $error("tx_byte3: expected %0h, got %0h", e.b3, rsp.tx_byte3); n_errors++;
        end
        if (rsp.tx_count !== e.cnt) begin
          $error("tx_count: expected %0d, got %0d", e.cnt, rsp.tx_count); n_errors++;
        end
        if (rsp.frame_last !== e.last) begin
          $error("frame_last: expected %0d, got %0d", e.last, rsp.frame_last); n_errors++;
        end
        if (rsp.read_value !== e.rval) begin
          $error("read_value: expected %0h, got %0h", e.rval, rsp.read_value); n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("modbus_tcp_slave_engine_core test failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.action = ACT_NET;
    req.rx_byte = '0;
    req.table_sel = SEL_COIL;
    req.table_index = '0;
    req.table_value = '0;
    rsp.ready = 1'b0;
    fpos = '0;
    held_high = '0;
    wr_armed = 1'b0;
    foreach (hdr[i]) hdr[i] = '0;
    foreach (coils[i]) coils[i] = 1'b0;
    foreach (discs[i]) discs[i] = 1'b0;
    foreach (iregs[i]) iregs[i] = '0;
    foreach (hregs[i]) hregs[i] = '0;

    // directed: table access extremes, read coil/holding and all write function codes, exceptions
    add_item(ACT_WR, 8'h00, SEL_COIL, 8'hFF, 16'hFFFF);
    add_item(ACT_WR, 8'hFF, SEL_DISC, 8'h00, 16'hFFFF);
    add_item(ACT_WR, 8'h00, SEL_IREG, 8'h7F, 16'hFFFF);
    add_item(ACT_WR, 8'h00, SEL_HREG, 8'hC8, 16'hA5A5);
    add_item(ACT_WR, 8'h00, SEL_HREG, 8'h00, 16'h8001);
    add_item(ACT_RD, 8'h00, SEL_COIL, 8'hFF, 16'h0000);
    add_item(ACT_RD, 8'h00, SEL_IREG, 8'hFF, 16'hFFFF);
    add_item(ACT_RD, 8'h00, SEL_HREG, 8'hC8, 16'h0000);
    add_item(2'd3, 8'hFF, SEL_HREG, 8'hFF, 16'hFFFF);
    add_frame(FC_RD_COILS, 16'd248, 16'd8, -1, -1);
    add_frame(FC_RD_HREGS, 16'd0, 16'd64, -1, -1);
    add_frame(FC_WR_COIL, 16'd255, 16'hFF00, -1, -1);
    add_frame(FC_WR_HREG, 16'd127, 16'hFFFF, -1, -1);
    add_frame(FC_WR_COILS, 16'd250, 16'd6, 1, -1);
    add_frame(FC_WR_HREGS, 16'd126, 16'd2, 4, -1);
    add_frame(FC_RD_COILS, 16'd0, 16'd2000, -1, -1);
    add_frame(FC_RD_HREGS, 16'hFFFF, 16'hFFFF, -1, -1);
    add_frame(FC_RD_COILS, 16'd5, 16'd0, -1, -1);
    add_frame(FC_WR_COIL, 16'd256, 16'd1, -1, -1);
    add_frame(8'h07, 16'd0, 16'd1, -1, -1);
    add_frame(FC_RD_DISC, 16'd0, 16'd1, -1, 0);
    add_frame(FC_RD_DISC, 16'd0, 16'd1, -1, 1);

    // random: mostly well-formed frames, some table traffic and noise
    while (stim_q.size() < 170) begin
      case ($urandom_range(19))
        0, 1, 2:
          add_item(ACT_WR, 8'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        3, 4, 5:
          add_item(ACT_RD, 8'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        6, 7, 8: add_noise();
        default: add_random_frame();
      endcase
    end
    n_total = stim_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || req.valid || pending_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_rsp_q.size() == 0) begin
      $display("modbus_tcp_slave_engine_core test passed");
    end else begin
      $display("modbus_tcp_slave_engine_core test failed");
    end
    $finish;
  end

endmodule
